/* rtl/elfck_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the elf load segment checker
package elfck_pkg;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned ADDR_W = 64;
	localparam int unsigned IMG_W = 32;
	localparam int unsigned TYPE_W = 32;
	localparam int unsigned CNT_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_ADDR = 1'b1;

	localparam logic [TYPE_W-1:0] TYPE_LOAD = 32'd1;
	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [ADDR_W-1:0] ALL_ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_ZERO_MEM,
		ERR_FILE_GT_MEM,
		ERR_OFF_PAST,
		ERR_DATA_PAST,
		ERR_WRAP,
		ERR_NO_LOAD,
		ERR_ENTRY
	} err_t;

	// one program header as held in the input stage
	typedef struct packed {
		logic              first_header;
		logic              last_header;
		logic [TYPE_W-1:0] segment_type;
		logic [ADDR_W-1:0] file_offset;
		logic [ADDR_W-1:0] virt_address;
		logic [ADDR_W-1:0] file_bytes;
		logic [ADDR_W-1:0] mem_bytes;
	} hdr_t;

	// verdict of the per-header checks
	typedef struct packed {
		err_t              err;
		logic              accum;
		logic [ADDR_W-1:0] seg_end;
		logic              covers;
	} chk_t;

endpackage

/* rtl/elfck_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for headers and results
interface elfck_hdr_if;
	logic                             valid;
	logic                             ready;
	logic                             first_header;
	logic                             last_header;
	logic [elfck_pkg::TYPE_W-1:0]     segment_type;
	logic [elfck_pkg::ADDR_W-1:0]     file_offset;
	logic [elfck_pkg::ADDR_W-1:0]     virt_address;
	logic [elfck_pkg::ADDR_W-1:0]     file_bytes;
	logic [elfck_pkg::ADDR_W-1:0]     mem_bytes;

	modport source (
		output valid, first_header, last_header, segment_type, file_offset,
			virt_address, file_bytes, mem_bytes,
		input ready
	);
	modport sink (
		input valid, first_header, last_header, segment_type, file_offset,
			virt_address, file_bytes, mem_bytes,
		output ready
	);
endinterface

interface elfck_res_if;
	logic                         valid;
	logic                         ready;
	logic                         done_res;
	logic                         ok;
	logic [2:0]                   error_code;
	logic [elfck_pkg::CNT_W-1:0]  seg_total;
	logic [elfck_pkg::ADDR_W-1:0] lowest_start;
	logic [elfck_pkg::ADDR_W-1:0] highest_end;

	modport source (
		output valid, done_res, ok, error_code, seg_total, lowest_start, highest_end,
		input ready
	);
	modport sink (
		input valid, done_res, ok, error_code, seg_total, lowest_start, highest_end,
		output ready
	);
endinterface

/* rtl/elf_load_segment_checker_top.sv */
`timescale 1ns / 1ps
// top level of the elf load segment checker
// Checks an ELF64 program header table one header per transaction and returns one
// result per header. A header is registered on input, checked against image_size and
// entry_address and the running table state, and the result is held in an output
// register, so the block takes one header every cycle while res.ready is high or the
// result register is empty. A header with first_header set clears the count, the lowest
// start, the highest end, the entry-covered flag and any latched error before it is
// checked. The first error is sticky until the next first header; a last header also
// rejects a table with no loadable segment or none covering the entry address.
// Configuration is written through cfg_we/cfg_index/cfg_data and takes effect at once;
// write it only while no header is in flight.
module elf_load_segment_checker_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [elfck_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [elfck_pkg::CFG_DATA_W-1:0] cfg_data,
	elfck_hdr_if.sink                      hdr,
	elfck_res_if.source                    res
);
	import elfck_pkg::*;

	logic [IMG_W-1:0]  image_size_q;
	logic [ADDR_W-1:0] entry_address_q;

	hdr_t              hdr_s1;
	logic              valid_s1;
	logic              valid_s2;
	logic              done_s2;
	err_t              err_s2;

	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] min_q;
	logic [ADDR_W-1:0] max_q;
	logic              seen_q;
	err_t              err_q;

	logic              adv;
	chk_t              chk;
	logic [CNT_W-1:0]  cnt_base, cnt_nxt;
	logic [ADDR_W-1:0] min_base, min_nxt;
	logic [ADDR_W-1:0] max_base, max_nxt;
	logic              seen_base, seen_nxt;
	err_t              err_base, err_nxt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q    <= '0;
			entry_address_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_SIZE: image_size_q    <= cfg_data[IMG_W-1:0];
				REG_ENTRY_ADDR: entry_address_q <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the result register is free or being emptied
	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign hdr.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.valid && hdr.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (hdr.valid && hdr.ready) begin
			hdr_s1.first_header <= hdr.first_header;
			hdr_s1.last_header  <= hdr.last_header;
			hdr_s1.segment_type <= hdr.segment_type;
			hdr_s1.file_offset  <= hdr.file_offset;
			hdr_s1.virt_address <= hdr.virt_address;
			hdr_s1.file_bytes   <= hdr.file_bytes;
			hdr_s1.mem_bytes    <= hdr.mem_bytes;
		end
	end

	elfck_seg_check u_check (
		.image_size    (image_size_q),
		.entry_address (entry_address_q),
		.hdr           (hdr_s1),
		.chk           (chk)
	);

	// table state seen by this header, cleared on a first header
	always_comb begin
		cnt_base  = hdr_s1.first_header ? '0         : cnt_q;
		min_base  = hdr_s1.first_header ? ALL_ONES64 : min_q;
		max_base  = hdr_s1.first_header ? '0         : max_q;
		seen_base = hdr_s1.first_header ? 1'b0       : seen_q;
		err_base  = hdr_s1.first_header ? ERR_NONE   : err_q;
	end

	// accumulate an accepted segment, then the table checks on a last header
	always_comb begin
		cnt_nxt  = cnt_base;
		min_nxt  = min_base;
		max_nxt  = max_base;
		seen_nxt = seen_base;
		err_nxt  = err_base;
		if (err_base == ERR_NONE) begin
			err_nxt = chk.err;
			if (chk.accum) begin
				if (hdr_s1.virt_address < min_base) min_nxt = hdr_s1.virt_address;
				if (chk.seg_end > max_base) max_nxt = chk.seg_end;
				if (chk.covers) seen_nxt = 1'b1;
				if (cnt_base != COUNT_MAX) cnt_nxt = cnt_base + 1'b1;
			end
			if (hdr_s1.last_header && (chk.err == ERR_NONE)) begin
				if (cnt_nxt == '0) begin
					err_nxt = ERR_NO_LOAD;
				end else if (!seen_nxt) begin
					err_nxt = ERR_ENTRY;
				end
			end
		end
	end

	// running table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			min_q  <= ALL_ONES64;
			max_q  <= '0;
			seen_q <= 1'b0;
			err_q  <= ERR_NONE;
		end else if (adv) begin
			cnt_q  <= cnt_nxt;
			min_q  <= min_nxt;
			max_q  <= max_nxt;
			seen_q <= seen_nxt;
			err_q  <= err_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			done_s2          <= hdr_s1.last_header;
			err_s2           <= err_nxt;
			res.seg_total    <= cnt_nxt;
			res.lowest_start <= min_nxt;
			res.highest_end  <= max_nxt;
		end
	end

	assign res.valid      = valid_s2;
	assign res.done_res   = done_s2;
	assign res.error_code = err_s2;
	assign res.ok         = (err_s2 == ERR_NONE);

	// a latched error holds until a first header
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !hdr_s1.first_header && (err_q != ERR_NONE)) |=> (err_q == $past(err_q)))
		else $error("latched error changed without a first header");

	// the count never falls between first headers
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !hdr_s1.first_header) |=> (cnt_q >= $past(cnt_q)))
		else $error("segment count decreased");

	// with no segment counted the bounds keep their empty values
	a_empty_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.seg_total == '0)) |->
		((res.lowest_start == ALL_ONES64) && (res.highest_end == '0)))
		else $error("bounds moved with no segment counted");

	// table level codes appear only on a last header
	a_table_code: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (err_base == ERR_NONE) && !hdr_s1.last_header) |->
		((err_nxt != ERR_NO_LOAD) && (err_nxt != ERR_ENTRY)))
		else $error("table check raised on a header that is not last");

	// an entry-uncovered verdict implies at least one segment
	a_entry_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.error_code == ERR_ENTRY)) |-> (res.seg_total != '0))
		else $error("entry error with no loadable segment");
endmodule

/* rtl/elfck_seg_check.sv */
`timescale 1ns / 1ps
// bounds and wrap checks of one program header
module elfck_seg_check (
	input  logic [elfck_pkg::IMG_W-1:0]  image_size,
	input  logic [elfck_pkg::ADDR_W-1:0] entry_address,
	input  elfck_pkg::hdr_t              hdr,
	output elfck_pkg::chk_t              chk
);
	import elfck_pkg::*;

	logic              is_load;
	logic [IMG_W-1:0]  room;
	logic [ADDR_W-1:0] room_ext;
	logic [ADDR_W-1:0] size_ext;
	logic              wraps;

	// bytes left after the offset; only used once offset is known to fit
	assign size_ext = {{(ADDR_W-IMG_W){1'b0}}, image_size};
	assign room     = image_size - hdr.file_offset[IMG_W-1:0];
	assign room_ext = {{(ADDR_W-IMG_W){1'b0}}, room};
	assign is_load  = (hdr.segment_type == TYPE_LOAD);
	// end at or past two to the 64 counts as a wrap
	assign wraps    = (hdr.mem_bytes > ~hdr.virt_address);

	// checks in priority order, first failure wins
	always_comb begin
		chk.err     = ERR_NONE;
		chk.accum   = 1'b0;
		chk.seg_end = hdr.virt_address + hdr.mem_bytes;
		chk.covers  = (entry_address >= hdr.virt_address) && (entry_address < chk.seg_end);
		if (is_load) begin
			if (hdr.mem_bytes == '0) begin
				if (hdr.file_bytes != '0) chk.err = ERR_ZERO_MEM;
			end else if (hdr.file_bytes > hdr.mem_bytes) begin
				chk.err = ERR_FILE_GT_MEM;
			end else if (hdr.file_offset > size_ext) begin
				chk.err = ERR_OFF_PAST;
			end else if (hdr.file_bytes > room_ext) begin
				chk.err = ERR_DATA_PAST;
			end else if (wraps) begin
				chk.err = ERR_WRAP;
			end else begin
				chk.accum = 1'b1;
			end
		end
	end
endmodule
